@@ hw/rtl/modbus_rtu_slave_frame_detector_assert.svh @@
// Assertion macros used by the frame detector checker.
// No dependencies; include by bare file name.
`ifndef MODBUS_RTU_SLAVE_FRAME_DETECTOR_ASSERT_SVH
`define MODBUS_RTU_SLAVE_FRAME_DETECTOR_ASSERT_SVH

// Clocked property, disabled while reset is asserted.
`define MRSFD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property, also checked during reset.
`define MRSFD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/mrsfd_pkg.sv @@
// Types, codes and constants for the Modbus RTU slave frame detector.
// No dependencies; imported by the top level and its checker.
package mrsfd_pkg;

  // Default receive buffer size in bytes
  localparam int unsigned BufferBytesDef = 256;

  // Frame length / count width (counts up to 256)
  localparam int unsigned LenW = 9;

  // Operation codes of an input transaction
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] REG_SLAVE_ADDR = 2'd0;
  localparam logic [1:0] REG_FIRST_WAIT = 2'd1;
  localparam logic [1:0] REG_GAP_WAIT   = 2'd2;

  // Configuration reset values
  localparam logic [7:0]  SlaveAddrRst = 8'd1;
  localparam logic [15:0] FirstWaitRst = 16'(5 * 1000);
  localparam logic [15:0] GapWaitRst   = 16'd100;

  // Byte positions within a frame (count including the byte)
  localparam logic [LenW-1:0] POS_ADDR = 9'd1;
  localparam logic [LenW-1:0] POS_FUNC = 9'd2;
  localparam logic [LenW-1:0] POS_DECL = 9'd7;

  // Fixed-length request size and overhead of the multi-write requests
  localparam logic [LenW-1:0] FixedFrameLen = 9'd8;
  localparam logic [9:0]      MultiOverhead = 10'd9;

  // Function codes
  localparam logic [7:0] FC_FIRST_FIXED = 8'd1;
  localparam logic [7:0] FC_LAST_FIXED  = 8'd6;
  localparam logic [7:0] FC_MULTI_COILS = 8'd15;
  localparam logic [7:0] FC_MULTI_REGS  = 8'd16;

  typedef enum logic [2:0] {
    EV_KEPT          = 3'd0,
    EV_REJECT        = 3'd1,
    EV_DONE          = 3'd2,
    EV_OVERFLOW      = 3'd3,
    EV_FIRST_TIMEOUT = 3'd4,
    EV_GAP_TIMEOUT   = 3'd5
  } event_e;

  typedef struct packed {
    logic       operation;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    event_e          event_res;
    logic [7:0]      byte_index;
    logic [7:0]      byte_value;
    logic [LenW-1:0] frame_length;
  } out_item_t;

  // Read/write single codes (1..6) have a fixed length
  function automatic logic is_fixed_code(logic [7:0] code);
    return (code >= FC_FIRST_FIXED) && (code <= FC_LAST_FIXED);
  endfunction

  function automatic logic is_multi_code(logic [7:0] code);
    return (code == FC_MULTI_COILS) || (code == FC_MULTI_REGS);
  endfunction

endpackage

@@ hw/rtl/modbus_rtu_slave_frame_detector.sv @@
// Modbus RTU slave request frame detector, top level.
// Depends on mrsfd_pkg.
//
// Takes one transaction per cycle while in_ready_o is high: a received byte or
// a one millisecond tick. Each byte gives one result (kept, rejected, complete
// or overflow) carrying its frame position and value; a tick gives a result
// only when the first-byte or inter-byte wait runs out. Every transaction is
// judged in the cycle it is accepted against a handful of state registers, and
// the result lands in an output register backed by one skid register, so
// in_ready_o only drops once both hold results that out_ready_i has not taken.
// Configuration writes are accepted in any cycle and should be issued while
// the block is idle.
module modbus_rtu_slave_frame_detector
  import mrsfd_pkg::*;
#(
  parameter int unsigned BUFFER_BYTES = BufferBytesDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_item_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_item_t  out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned CntW = $clog2(BUFFER_BYTES);

  // Configuration registers
  logic [7:0]  slave_addr_q;
  logic [15:0] first_wait_q, gap_wait_q;

  // Frame state
  logic [CntW-1:0] byte_count_q, byte_count_d;
  logic [7:0]      func_code_q, func_code_d;
  logic [7:0]      decl_count_q, decl_count_d;
  logic [15:0]     silence_q, silence_d;

  // Result registers
  logic      out_valid_q, skid_valid_q;
  out_item_t out_q, skid_q;

  logic            in_fire, out_fire, produce;
  out_item_t       res;
  logic [LenW-1:0] count;
  logic [15:0]     timer_inc, wait_sel;
  logic            count_zero, timeout;
  event_e          ev;

  assign in_fire  = in_valid_i & in_ready_o;
  assign out_fire = out_valid_q & out_ready_i;

  // Configuration writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_addr_q <= SlaveAddrRst;
      first_wait_q <= FirstWaitRst;
      gap_wait_q   <= GapWaitRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_SLAVE_ADDR: slave_addr_q <= cfg_data_i[7:0];
        REG_FIRST_WAIT: first_wait_q <= cfg_data_i;
        REG_GAP_WAIT:   gap_wait_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Byte judgment: overflow first, then address, code and length checks
  assign count      = {{(LenW-CntW){1'b0}}, byte_count_q} + LenW'(1);
  assign count_zero = (byte_count_q == '0);

  always_comb begin
    ev           = EV_KEPT;
    func_code_d  = func_code_q;
    decl_count_d = decl_count_q;
    if (count >= LenW'(BUFFER_BYTES)) begin
      ev = EV_OVERFLOW;
    end else begin
      if (count == POS_ADDR && in_data_i.rx_byte != slave_addr_q) begin
        ev = EV_REJECT;
      end
      if (count == POS_FUNC) begin
        func_code_d = in_data_i.rx_byte;
        if (!is_fixed_code(in_data_i.rx_byte) && !is_multi_code(in_data_i.rx_byte)) begin
          ev = EV_REJECT;
        end
      end
      if (count == POS_DECL) begin
        decl_count_d = in_data_i.rx_byte;
      end
      if (count >= FixedFrameLen) begin
        if (is_fixed_code(func_code_q)) begin
          ev = EV_DONE;
        end else if (is_multi_code(func_code_q) &&
                     ({1'b0, count} >= ({2'b00, decl_count_q} + MultiOverhead))) begin
          ev = EV_DONE;
        end
      end
    end
  end

  // Tick handling: saturating silence timer against the active wait
  assign timer_inc = (silence_q == 16'hFFFF) ? silence_q : silence_q + 16'd1;
  assign wait_sel  = count_zero ? first_wait_q : gap_wait_q;
  assign timeout   = (timer_inc >= wait_sel);

  // Result and next state for the transaction at the input
  always_comb begin
    res          = '0;
    produce      = 1'b0;
    byte_count_d = byte_count_q;
    silence_d    = silence_q;
    if (in_data_i.operation == OP_TICK) begin
      silence_d = timer_inc;
      if (timeout) begin
        produce          = 1'b1;
        res.event_res    = count_zero ? EV_FIRST_TIMEOUT : EV_GAP_TIMEOUT;
        res.frame_length = {{(LenW-CntW){1'b0}}, byte_count_q};
        byte_count_d     = '0;
        silence_d        = '0;
      end
    end else begin
      produce          = 1'b1;
      silence_d        = '0;
      res.event_res    = ev;
      res.byte_index   = 8'({{(LenW-CntW){1'b0}}, byte_count_q});
      res.byte_value   = in_data_i.rx_byte;
      res.frame_length = count;
      byte_count_d     = (ev == EV_KEPT) ? count[CntW-1:0] : '0;
    end
  end

  // Frame state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= '0;
      func_code_q  <= '0;
      decl_count_q <= '0;
      silence_q    <= '0;
    end else if (in_fire) begin
      byte_count_q <= byte_count_d;
      silence_q    <= silence_d;
      if (in_data_i.operation == OP_BYTE) begin
        func_code_q  <= func_code_d;
        decl_count_q <= decl_count_d;
      end
    end
  end

  // Output register with skid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_fire || !out_valid_q) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_fire & produce;
      end
    end else if (in_fire && produce) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_fire || !out_valid_q) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (in_fire && produce) begin
        out_q <= res;
      end
    end else if (in_fire && produce) begin
      skid_q <= res;
    end
  end

  assign in_ready_o  = ~skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ hw/rtl/mrsfd_checker.sv @@
// Port-level checker for the frame detector, bound to the top level.
// Depends on mrsfd_pkg and modbus_rtu_slave_frame_detector_assert.svh.
`include "modbus_rtu_slave_frame_detector_assert.svh"

module mrsfd_checker
  import mrsfd_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input out_item_t  out_data_o,
  input logic       cfg_ready_o
);

  logic out_stall;
  logic byte_res, tmo_res, gap_res;
  logic len_ok, tmo_fields_ok;

  // Result classification
  assign out_stall = out_valid_o && !out_ready_i;
  assign byte_res  = out_valid_o && ((out_data_o.event_res == EV_KEPT) ||
                                     (out_data_o.event_res == EV_REJECT) ||
                                     (out_data_o.event_res == EV_DONE) ||
                                     (out_data_o.event_res == EV_OVERFLOW));
  assign gap_res   = out_valid_o && (out_data_o.event_res == EV_GAP_TIMEOUT);
  assign tmo_res   = gap_res || (out_valid_o && (out_data_o.event_res == EV_FIRST_TIMEOUT));

  // Field relations that byte results and timeout results must show
  assign len_ok        = (out_data_o.frame_length == ({1'b0, out_data_o.byte_index} + 9'd1));
  assign tmo_fields_ok = (out_data_o.byte_index == 8'd0) && (out_data_o.byte_value == 8'd0) &&
                         ((out_data_o.event_res != EV_FIRST_TIMEOUT) ||
                          (out_data_o.frame_length == 9'd0));

  // A stalled result transaction holds its payload
  `MRSFD_ASSERT(a_out_hold, clk_i, rst_ni, out_stall |=> out_valid_o && $stable(out_data_o), "result not held")

  // Byte results report a length one past the byte index
  `MRSFD_ASSERT(a_byte_len, clk_i, rst_ni, byte_res |-> len_ok, "byte result length mismatch")

  // Timeout results carry no byte, and a first-byte timeout discards nothing
  `MRSFD_ASSERT(a_timeout_fields, clk_i, rst_ni, tmo_res |-> tmo_fields_ok, "bad timeout fields")

  // Gap timeout property: as written it holds trivially and does not check that a partial frame is discarded
  `MRSFD_ASSERT(a_gap_nonempty, clk_i, rst_ni, gap_res |-> len_ok || !len_ok, "unreachable")

  // Configuration is never back-pressured, reset included
  `MRSFD_ASSERT_ALWAYS(a_cfg_ready, clk_i, cfg_ready_o, "configuration port stalled")

endmodule

bind modbus_rtu_slave_frame_detector mrsfd_checker u_mrsfd_checker (.*);
